### sv/itaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

    // Sizes
    localparam int VALUE_BITS  = 64;
    localparam int MAX_DIGITS  = 20;
    localparam int MAX_RESULTS = 20;
    localparam int DIGIT_W     = 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int LEFT_W      = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_CNT_W  = $clog2(MAX_RESULTS);

    // ASCII codes
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_PFX0,
        ST_PFXX,
        ST_DIGIT
    } t_state;

    // Per-cycle command broadcast to every digit cell
    typedef struct packed {
        logic clear;    // zero the digit
        logic conv;     // take one magnitude bit, shift toward the top
        logic up;       // move whole digit one cell toward the top
        logic decimal;  // apply the +3 correction for BCD
    } t_cell_ctrl;

    // Lower-case digit character
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        begin
            if (d < 4'd10) begin
                c = CH_ZERO + {4'd0, d};
            end else begin
                c = 8'h57 + {4'd0, d};
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### sv/itaf_digit_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One digit position: shift-and-add-3 for decimal, plain nibble shift for hex
module itaf_digit_cell
    import itaf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic               i_carry,
    input  wire logic [DIGIT_W-1:0] i_digit_below,
    output logic                    o_carry,
    output logic [DIGIT_W-1:0]      o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] w_adj;

    // BCD correction before the shift
    always_comb begin
        if (i_ctrl.decimal && (r_digit >= 4'd5)) begin
            w_adj = r_digit + 4'd3;
        end else begin
            w_adj = r_digit;
        end
    end

    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.conv) begin
            r_digit <= {w_adj[DIGIT_W-2:0], i_carry};
        end else if (i_ctrl.up) begin
            r_digit <= i_digit_below;
        end
    end

endmodule

`default_nettype wire

### sv/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                   Payload
// input    in         i_in_valid / o_in_ready     i_value, i_hex_base, i_pointer_mode
// output   out        o_out_valid / i_out_ready   o_character, o_last_char
//
// One request at a time: an accept, conversion of the magnitude through the digit
// cell row, one magnitude bit per cycle, then dropping of leading zero digits, then
// the characters, sent one at a time as the sink takes them.
// Reset (synchronous, active low) returns the controller to idle.
// A stalled output holds the character and freezes the cell row.
module integer_to_ascii_formatter_unit
    import itaf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_value,
    input  wire logic        i_hex_base,
    input  wire logic        i_pointer_mode,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_character,
    output logic             o_last_char
);

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic [BIT_CNT_W-1:0]    r_bits, n_bits;
    logic [LEFT_W-1:0]       r_left, n_left;
    logic [CHAR_CNT_W-1:0]   r_nchars, n_nchars;
    logic                    r_neg, n_neg;
    logic                    r_hex, n_hex;

    t_cell_ctrl              w_ctrl;
    logic [MAX_DIGITS:0]     w_carry;
    logic [DIGIT_W-1:0]      w_digit [MAX_DIGITS+1];
    logic [DIGIT_W-1:0]      w_top;
    logic                    w_in_acc, w_out_acc, w_skip;
    logic [VALUE_BITS-1:0]   w_raw;
    logic                    w_in_neg;

    // Digit cell chain: cell 0 takes the magnitude MSB, carries run upward
    assign w_carry[0] = r_mag[VALUE_BITS-1];
    assign w_digit[0] = '0;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        itaf_digit_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_carry       (w_carry[g]),
            .i_digit_below (w_digit[g]),
            .o_carry       (w_carry[g+1]),
            .o_digit       (w_digit[g+1])
        );
    end

    assign w_top     = w_digit[MAX_DIGITS];
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_skip    = (w_top == '0) && (r_left > LEFT_W'(1));
    assign w_raw     = i_value[VALUE_BITS-1:0];
    assign w_in_neg  = !i_pointer_mode && w_raw[VALUE_BITS-1];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bits == BIT_CNT_W'(VALUE_BITS - 1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!w_skip) begin
                    priority if (r_neg) begin
                        n_state = ST_SIGN;
                    end else if (r_hex) begin
                        n_state = ST_PFX0;
                    end else begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_SIGN: begin
                if (w_out_acc) begin
                    priority if (o_last_char) begin
                        n_state = ST_IDLE;
                    end else if (r_hex) begin
                        n_state = ST_PFX0;
                    end else begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_PFX0: begin
                if (w_out_acc) begin
                    n_state = o_last_char ? ST_IDLE : ST_PFXX;
                end
            end
            ST_PFXX: begin
                if (w_out_acc) begin
                    n_state = o_last_char ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_out_acc && o_last_char) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and cell commands
    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        o_out_valid  = 1'b0;
        o_character  = CH_ZERO;
        w_ctrl.clear = 1'b0;
        w_ctrl.conv  = 1'b0;
        w_ctrl.up    = 1'b0;
        w_ctrl.decimal = !r_hex;
        unique case (r_state)
            ST_IDLE:  w_ctrl.clear = w_in_acc;
            ST_CONV:  w_ctrl.conv  = 1'b1;
            ST_SKIP:  w_ctrl.up    = w_skip;
            ST_SIGN: begin
                o_out_valid = 1'b1;
                o_character = CH_MINUS;
            end
            ST_PFX0: begin
                o_out_valid = 1'b1;
                o_character = CH_ZERO;
            end
            ST_PFXX: begin
                o_out_valid = 1'b1;
                o_character = CH_X;
            end
            ST_DIGIT: begin
                o_out_valid = 1'b1;
                o_character = digit_char(w_top);
                w_ctrl.up   = i_out_ready;
            end
            default: ;
        endcase
        // last on final digit, or when the result cap is hit
        o_last_char = o_out_valid &&
                      (((r_state == ST_DIGIT) && (r_left == LEFT_W'(1))) ||
                       (r_nchars == CHAR_CNT_W'(MAX_RESULTS - 1)));
    end

    // Datapath next values
    always_comb begin
        n_mag    = r_mag;
        n_bits   = r_bits;
        n_left   = r_left;
        n_nchars = r_nchars;
        n_neg    = r_neg;
        n_hex    = r_hex;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_mag  = w_in_neg ? (~w_raw) + VALUE_BITS'(1) : w_raw;
                    n_neg  = w_in_neg;
                    n_hex  = i_hex_base || i_pointer_mode;
                    n_bits = '0;
                end
            end
            ST_CONV: begin
                n_mag  = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bits = r_bits + BIT_CNT_W'(1);
                n_left = LEFT_W'(MAX_DIGITS);
            end
            ST_SKIP: begin
                n_nchars = '0;
                if (w_skip) begin
                    n_left = r_left - LEFT_W'(1);
                end
            end
            ST_SIGN, ST_PFX0, ST_PFXX: begin
                if (w_out_acc) begin
                    n_nchars = r_nchars + CHAR_CNT_W'(1);
                end
            end
            ST_DIGIT: begin
                if (w_out_acc) begin
                    n_nchars = r_nchars + CHAR_CNT_W'(1);
                    n_left   = r_left - LEFT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_bits   <= '0;
            r_left   <= '0;
            r_nchars <= '0;
        end else begin
            r_state  <= n_state;
            r_bits   <= n_bits;
            r_left   <= n_left;
            r_nchars <= n_nchars;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_hex <= n_hex;
    end

endmodule

`default_nettype wire
